[hdl/pwotc_pkg.sv]
`default_nettype none

package pwotc_pkg;

    // hold counter and one-touch limit widths
    localparam int HOLD_COUNT_BITS = 24;
    localparam int LIMIT_BITS      = 24;
    localparam int CMP_BITS        = (HOLD_COUNT_BITS > LIMIT_BITS) ? HOLD_COUNT_BITS
                                                                     : LIMIT_BITS;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(200000);

    typedef logic [HOLD_COUNT_BITS-1:0] hold_count_t;
    typedef logic [LIMIT_BITS-1:0]      limit_t;
    typedef logic [2:0]                 mode_t;
    typedef logic [1:0]                 drive_t;

    // window modes
    localparam mode_t MODE_IDLE      = 3'd0;
    localparam mode_t MODE_HOLD_UP   = 3'd1;
    localparam mode_t MODE_HOLD_DOWN = 3'd2;
    localparam mode_t MODE_AUTO_UP   = 3'd3;
    localparam mode_t MODE_AUTO_DOWN = 3'd4;

    // motor commands
    localparam drive_t DRIVE_STOP = 2'd0;
    localparam drive_t DRIVE_UP   = 2'd1;
    localparam drive_t DRIVE_DOWN = 2'd2;

    // input beat bit positions
    localparam int BIT_DRIVER_UP_N       = 0;
    localparam int BIT_DRIVER_DOWN_N     = 1;
    localparam int BIT_PASSENGER_UP_N    = 2;
    localparam int BIT_PASSENGER_DOWN_N  = 3;
    localparam int BIT_PASSENGER_LOCKED  = 4;
    localparam int BIT_TOP_CLEAR         = 5;
    localparam int BIT_BOTTOM_CLEAR      = 6;

endpackage

`default_nettype wire

[hdl/power_window_one_touch_controller.sv]
`default_nettype none

// one-touch power window controller. every input beat is one tick of sampled
// switch levels (active low) plus the lock and limit inputs; every beat gives
// exactly one result beat with the motor command and the mode after the tick.
// a tick is taken every cycle when the result side keeps up; the result shows
// in the cycle after its input beat, from the single result register, which
// also sets the rate: a new beat is taken whenever that register is empty or is
// being read in the same cycle. in idle the switches are checked in the order
// driver up, driver down, passenger up, passenger down (passenger only when
// not locked). a hold runs the motor and counts ticks, saturating; on release
// a hold shorter than one_touch_limit, with its limit not yet reached, turns
// into one-touch travel until that limit is reached; else it stops. the user
// must write one_touch_limit through cfg_wen / cfg_wdata only while the block
// is idle (the block itself does not enforce this); it resets to 200000.
module power_window_one_touch_controller (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // configuration: one_touch_limit
    input  wire logic       cfg_wen,
    input  wire logic [pwotc_pkg::LIMIT_BITS-1:0] cfg_wdata,
    // tick beats
    input  wire logic       s_tvalid,
    output logic            s_tready,
    // tdata from bit 0: driver_up_n, driver_down_n, passenger_up_n,
    // passenger_down_n, passenger_locked, top_clear, bottom_clear, pad
    input  wire logic [7:0] s_tdata,
    // result beats
    output logic            m_tvalid,
    input  wire logic       m_tready,
    // tdata from bit 0: motor_drive[1:0], window_mode[4:2], pad[7:5]
    output logic [7:0]      m_tdata
);
    import pwotc_pkg::*;

    // state
    limit_t      limit_reg;
    mode_t       mode_reg,       mode_next;
    logic        from_pas_reg,   from_pas_next;
    hold_count_t hold_count_reg, hold_count_next;
    // result register
    logic        m_valid_reg;
    drive_t      drive_reg,      drive_next;
    mode_t       out_mode_reg;

    logic accept;

    // decoded tick
    logic drv_up, drv_dn, pas_up, pas_dn, locked, top_ok, bot_ok;
    logic hold_up, held, clear, short_hold;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign drv_up = !s_tdata[BIT_DRIVER_UP_N];
    assign drv_dn = !s_tdata[BIT_DRIVER_DOWN_N];
    assign pas_up = !s_tdata[BIT_PASSENGER_UP_N];
    assign pas_dn = !s_tdata[BIT_PASSENGER_DOWN_N];
    assign locked = s_tdata[BIT_PASSENGER_LOCKED];
    assign top_ok = s_tdata[BIT_TOP_CLEAR];
    assign bot_ok = s_tdata[BIT_BOTTOM_CLEAR];

    // direction of the current hold or travel
    assign hold_up = (mode_reg == MODE_HOLD_UP) || (mode_reg == MODE_AUTO_UP);
    // only the switch that started the hold is watched
    assign held    = from_pas_reg ? (hold_up ? pas_up : pas_dn)
                                  : (hold_up ? drv_up : drv_dn);
    assign clear   = hold_up ? top_ok : bot_ok;
    assign short_hold = CMP_BITS'(hold_count_reg) < CMP_BITS'(limit_reg);

    always_comb begin
        mode_next       = mode_reg;
        from_pas_next   = from_pas_reg;
        hold_count_next = hold_count_reg;
        drive_next      = DRIVE_STOP;
        case (mode_reg)
            MODE_HOLD_UP, MODE_HOLD_DOWN: begin
                if (held) begin
                    // saturating tick count
                    if (hold_count_reg != '1) begin
                        hold_count_next = hold_count_reg + HOLD_COUNT_BITS'(1);
                    end
                    drive_next = hold_up ? DRIVE_UP : DRIVE_DOWN;
                end else begin
                    if (short_hold && clear) begin
                        mode_next  = hold_up ? MODE_AUTO_UP : MODE_AUTO_DOWN;
                        drive_next = hold_up ? DRIVE_UP : DRIVE_DOWN;
                    end else begin
                        mode_next = MODE_IDLE;
                    end
                    hold_count_next = '0;
                end
            end
            MODE_AUTO_UP, MODE_AUTO_DOWN: begin
                // one-touch travel runs until its limit
                if (clear) begin
                    drive_next = hold_up ? DRIVE_UP : DRIVE_DOWN;
                end else begin
                    mode_next = MODE_IDLE;
                end
            end
            default: begin
                // idle, switch priority order
                mode_next = MODE_IDLE;
                if (drv_up) begin
                    mode_next     = MODE_HOLD_UP;
                    from_pas_next = 1'b0;
                end else if (drv_dn) begin
                    mode_next     = MODE_HOLD_DOWN;
                    from_pas_next = 1'b0;
                end else if (!locked && pas_up) begin
                    mode_next     = MODE_HOLD_UP;
                    from_pas_next = 1'b1;
                end else if (!locked && pas_dn) begin
                    mode_next     = MODE_HOLD_DOWN;
                    from_pas_next = 1'b1;
                end
                // the first tick of a hold already drives the motor
                if (mode_next != MODE_IDLE) begin
                    hold_count_next = HOLD_COUNT_BITS'(1);
                    drive_next = (mode_next == MODE_HOLD_UP) ? DRIVE_UP : DRIVE_DOWN;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg      <= LIMIT_RESET;
            mode_reg       <= MODE_IDLE;
            from_pas_reg   <= 1'b0;
            hold_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wen) begin
                limit_reg <= cfg_wdata;
            end
            if (accept) begin
                mode_reg       <= mode_next;
                from_pas_reg   <= from_pas_next;
                hold_count_reg <= hold_count_next;
                m_valid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            drive_reg    <= drive_next;
            out_mode_reg <= mode_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_mode_reg, drive_reg};

    // the reported mode is always the stored mode
    a_mode_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_mode_reg == mode_reg))
        else $error("result mode differs from stored mode");

    // the counter runs exactly while a hold is in progress
    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ((mode_reg == MODE_HOLD_UP) || (mode_reg == MODE_HOLD_DOWN))
            == (hold_count_reg != '0))
        else $error("hold counter out of step with mode");

    // the motor is stopped exactly when the block reports idle
    a_stop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((drive_reg == DRIVE_STOP) == (out_mode_reg == MODE_IDLE)))
        else $error("motor command inconsistent with mode");

    // an upward command only comes with an upward mode
    a_up_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (drive_reg == DRIVE_UP)) |->
            ((out_mode_reg == MODE_HOLD_UP) || (out_mode_reg == MODE_AUTO_UP)))
        else $error("up command in a non-up mode");

endmodule

`default_nettype wire
